// ----- rtl/gkc_pkg.sv -----
// gkc_pkg: shared constants for the gabor kernel coefficient unit
// register codes, fixed-point constants, polynomial and reciprocal tables
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gkc_pkg;

    localparam int MAX_SIZE = 16;

    localparam int SIN_LAT = 6;

    localparam logic [2:0] REG_KERNEL_SIZE   = 3'd0;
    localparam logic [2:0] REG_WAVELENGTH    = 3'd1;
    localparam logic [2:0] REG_ORIENTATION   = 3'd2;
    localparam logic [2:0] REG_CARRIER_PHASE = 3'd3;
    localparam logic [2:0] REG_SIGMA         = 3'd4;
    localparam logic [2:0] REG_ASPECT_RATIO  = 3'd5;
    localparam logic [2:0] REG_USE_SINE      = 3'd6;
    localparam logic [2:0] REG_AMPLITUDE     = 3'd7;

    localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    localparam logic [30:0] SK9 = 31'd172272;
    // horner coefficients after the degree 9 term: sk7, sk5, sk3, sk1
    localparam logic [30:0] SIN_HORNER [0:3] = '{
        31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [22:0] EXP_CAP   = 23'h40_0000;

    localparam int HN = 7;
    // reciprocals, rounded up, for the exp series divisors 7 down to 1
    localparam logic [30:0] HK_RECIP [0:HN-1] = '{
        31'(((64'd1 << 33) + 64'd6) / 64'd7),
        31'(((64'd1 << 33) + 64'd5) / 64'd6),
        31'(((64'd1 << 33) + 64'd4) / 64'd5),
        31'((64'd1 << 32) / 64'd4),
        31'(((64'd1 << 32) + 64'd2) / 64'd3),
        31'((64'd1 << 31) / 64'd2),
        31'(64'd1 << 30)
    };
    localparam int HK_SHIFT [0:HN-1] = '{33, 33, 33, 32, 32, 31, 30};

endpackage

`default_nettype wire

// ----- rtl/gkc_sin.sv -----
// gkc_sin: pipelined q30 sine of a 16-bit turn angle, six register stages
// quarter-wave fold, odd taylor polynomial in horner form
// depends on gkc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gkc_sin (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_turn,
    output logic signed [31:0] o_val
);
    import gkc_pkg::*;

    logic [14:0] n_r;
    logic [30:0] n_u;
    logic [61:0] n_u2;
    logic [30:0] w_pin [0:3];
    logic [61:0] n_s;
    logic [30:0] n_sc;

    logic [30:0] r_u   [0:4];
    logic [30:0] r_u2  [0:3];
    logic        r_neg [0:4];
    logic [30:0] r_p   [0:3];

    always_comb begin
        n_r  = i_turn[14] ? (15'd16384 - {1'b0, i_turn[13:0]}) : {1'b0, i_turn[13:0]};
        n_u  = {n_r, 16'd0};
        n_u2 = 62'(n_u) * 62'(n_u);
        w_pin[0] = SK9;
        for (int k = 1; k < 4; k++) begin
            w_pin[k] = r_p[k-1];
        end
        n_s  = 62'(r_u[4]) * 62'(r_p[3]);
        n_sc = (n_s[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : n_s[60:30];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u[0]   <= n_u;
            r_u2[0]  <= n_u2[60:30];
            r_neg[0] <= i_turn[15];
            for (int k = 1; k < 5; k++) begin
                r_u[k]   <= r_u[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            for (int k = 1; k < 4; k++) begin
                r_u2[k] <= r_u2[k-1];
            end
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= SIN_HORNER[k] - 31'((62'(r_u2[k]) * 62'(w_pin[k])) >> 30);
            end
            o_val <= r_neg[4] ? -$signed({1'b0, n_sc}) : $signed({1'b0, n_sc});
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gkc_div.sv -----
// gkc_div: pipelined restoring divider, one quotient bit per stage
// the quotient must fit Q_W bits; the block does not register the divisor, the user must hold it for the whole transit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gkc_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 16,
    parameter int Q_W   = 30
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quot
);
    localparam int SW = DEN_W + Q_W;
    localparam int CW = (NUM_W > SW) ? NUM_W : SW;

    logic [CW-1:0]  r_rem  [0:Q_W-2];
    logic [Q_W-1:0] r_quot [0:Q_W-1];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        localparam int B = Q_W - 1 - s;
        logic [CW-1:0]  w_rem;
        logic [CW-1:0]  w_trial;
        logic [Q_W-1:0] w_q;
        logic           w_fit;

        if (s == 0) begin : g_first
            assign w_rem = CW'(i_num);
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_q   = r_quot[s-1];
        end

        assign w_trial = CW'(i_den) << B;
        assign w_fit   = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quot[s] <= w_fit ? (w_q | (Q_W'(1) << B)) : w_q;
            end
        end

        if (s < Q_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_fit ? (w_rem - w_trial) : w_rem;
                end
            end
        end
    end

    assign o_quot = r_quot[Q_W-1];

endmodule

`default_nettype wire

// ----- rtl/gabor_kernel_coefficient_unit.sv -----
// gabor_kernel_coefficient_unit: integer gabor kernel coefficient per coordinate
// fully pipelined datapath with output register and one skid entry
// depends on gkc_pkg, gkc_sin, gkc_div
//
// usage:
//   apb port sets the kernel registers at byte address 4*index; pready is always
//   high, reads return the register value. write only while the pipeline is empty.
//   input channel i_valid/o_ready carries one (i_col, i_row) beat per coordinate.
//   output channel o_valid/i_ready carries o_coefficient and o_out_of_range.
//   the pipeline depth is set by the envelope path (six-stage sine units,
//   23-stage exponent divider, seven two-stage exp series steps and the final
//   multiplies).
//   throughput: one coordinate per cycle while the receiver takes results.
//   reset: synchronous, active low; clears all valid bits and restores the
//   register defaults (5x5 kernel, wavelength 2.0, sigma 181/256, amplitude 255).
//   stall: a held result sits in the output register, the next one goes to the
//   skid entry; once that is full o_ready drops and the whole pipeline freezes
//   until the output register is taken.
`timescale 1ns / 1ps
`default_nettype none

module gabor_kernel_coefficient_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_col,
    input  logic [3:0]         i_row,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_coefficient,
    output logic               o_out_of_range
);
    import gkc_pkg::*;

    localparam int ENV_NUM_W = 61;
    localparam int ENV_DEN_W = 35;
    localparam int ENV_Q     = 23;
    localparam int CAR_NUM_W = 30;
    localparam int CAR_DEN_W = 16;
    localparam int CAR_Q     = 30;
    localparam int ENV_END   = SIN_LAT + 2 + 3 + ENV_Q + 2 + 2 * HN + 1;
    localparam int CAR_END   = SIN_LAT + 2 + 1 + CAR_Q + 1 + SIN_LAT;
    localparam int CAR_DLY   = ENV_END - CAR_END;
    localparam int TOTAL     = ENV_END + 2;

    typedef struct packed {
        logic [29:0] w;
        logic        kbig;
        logic [4:0]  kshift;
    } t_env_side;

    // configuration
    logic [4:0]  r_kernel_size;
    logic [15:0] r_wavelength;
    logic [15:0] r_orientation;
    logic [15:0] r_carrier_phase;
    logic [15:0] r_sigma;
    logic [15:0] r_aspect_ratio;
    logic        r_use_sine;
    logic [14:0] r_amplitude;
    logic [34:0] r_den;
    logic [31:0] r_asp2;
    logic [15:0] w_lw;
    logic [15:0] w_sg;
    logic        w_wr;

    // control
    logic             w_en;
    logic             w_push;
    logic [TOTAL-1:0] r_vline;
    logic             r_oline [0:TOTAL-1];

    // input stage
    logic [4:0]        w_kn;
    logic              w_oor;
    logic signed [6:0] w_dx;
    logic signed [6:0] w_dy;
    logic signed [6:0] r_dx [0:SIN_LAT-1];
    logic signed [6:0] r_dy [0:SIN_LAT-1];
    logic [15:0]       w_cos_turn;
    logic signed [31:0] w_ca;
    logic signed [31:0] w_sa;

    // rotation
    logic signed [38:0] r_pxc, r_pys, r_pyc, r_pxs;
    logic signed [39:0] n_vx, n_vy;
    logic [39:0]        n_mx, n_my;
    logic [21:0]        r_xm, r_ym;
    logic               r_xneg;

    // envelope
    logic [43:0]  r_xm2, r_ym2, r_xm2_d;
    logic [59:0]  r_prod;
    logic [60:0]  n_d;
    logic [60:0]  r_d;
    logic         r_sat;
    logic         r_sat_d [0:ENV_Q-1];
    logic [22:0]  w_eq;
    logic [22:0]  n_e;
    logic [39:0]  n_z;
    logic [23:0]  r_z;
    logic [45:0]  n_w;
    logic [29:0]  r_w;
    logic         r_kbig;
    logic [4:0]   r_kshift;
    t_env_side    r_side [0:2*HN-1];
    logic [29:0]  w_hw [0:HN-1];
    logic [30:0]  w_ht [0:HN-1];
    logic [29:0]  r_hp [0:HN-1];
    logic [30:0]  r_ht [0:HN-1];
    logic [30:0]  r_g;

    // carrier
    logic [29:0]        r_cnum;
    logic               r_cneg;
    logic               r_cneg_d [0:CAR_Q-1];
    logic [29:0]        w_cq;
    logic [15:0]        n_step;
    logic [15:0]        r_ang;
    logic signed [31:0] w_car;
    logic signed [31:0] r_car_d [0:CAR_DLY-1];
    logic [30:0]        n_cm;

    // product and output
    logic [61:0]        n_gc;
    logic [30:0]        r_gc;
    logic               r_cneg2;
    logic [45:0]        n_v;
    logic signed [15:0] n_coef;
    logic signed [15:0] r_coef;
    logic               r_ovalid, r_svalid;
    logic signed [15:0] r_ocoef, r_scoef;
    logic               r_ooor, r_soor;

    // apb register file
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_size   <= 5'd5;
            r_wavelength    <= 16'd512;
            r_orientation   <= 16'd0;
            r_carrier_phase <= 16'd0;
            r_sigma         <= 16'd181;
            r_aspect_ratio  <= 16'd256;
            r_use_sine      <= 1'b0;
            r_amplitude     <= 15'd255;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_KERNEL_SIZE:   r_kernel_size   <= pwdata[4:0];
                REG_WAVELENGTH:    r_wavelength    <= pwdata[15:0];
                REG_ORIENTATION:   r_orientation   <= pwdata[15:0];
                REG_CARRIER_PHASE: r_carrier_phase <= pwdata[15:0];
                REG_SIGMA:         r_sigma         <= pwdata[15:0];
                REG_ASPECT_RATIO:  r_aspect_ratio  <= pwdata[15:0];
                REG_USE_SINE:      r_use_sine      <= pwdata[0];
                REG_AMPLITUDE:     r_amplitude     <= pwdata[14:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_KERNEL_SIZE:   prdata = 32'(r_kernel_size);
            REG_WAVELENGTH:    prdata = 32'(r_wavelength);
            REG_ORIENTATION:   prdata = 32'(r_orientation);
            REG_CARRIER_PHASE: prdata = 32'(r_carrier_phase);
            REG_SIGMA:         prdata = 32'(r_sigma);
            REG_ASPECT_RATIO:  prdata = 32'(r_aspect_ratio);
            REG_USE_SINE:      prdata = 32'(r_use_sine);
            REG_AMPLITUDE:     prdata = 32'(r_amplitude);
        endcase
    end

    assign w_lw = (r_wavelength == 16'd0) ? 16'd1 : r_wavelength;
    assign w_sg = (r_sigma == 16'd0) ? 16'd1 : r_sigma;

    always_ff @(posedge i_clk) begin
        r_den  <= (35'(w_sg) * 35'(w_sg)) << 3;
        r_asp2 <= 32'(r_aspect_ratio) * 32'(r_aspect_ratio);
    end

    // handshake
    assign w_en    = !r_svalid;
    assign o_ready = w_en;
    assign w_push  = w_en && r_vline[TOTAL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vline <= '0;
        end else if (w_en) begin
            r_vline <= {r_vline[TOTAL-2:0], i_valid};
        end
    end

    // coordinate centering
    assign w_kn  = (r_kernel_size > 5'(MAX_SIZE)) ? 5'(MAX_SIZE) : r_kernel_size;
    assign w_oor = (5'(i_col) >= w_kn) || (5'(i_row) >= w_kn);
    assign w_dx  = $signed({2'b00, i_col, 1'b0}) - $signed({2'b00, w_kn}) + 7'sd1;
    assign w_dy  = $signed({2'b00, i_row, 1'b0}) - $signed({2'b00, w_kn}) + 7'sd1;
    assign w_cos_turn = r_orientation + QUARTER_TURN;

    gkc_sin u_sin_cos (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_turn (w_cos_turn),
        .o_val  (w_ca)
    );

    gkc_sin u_sin_sin (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_turn (r_orientation),
        .o_val  (w_sa)
    );

    always_comb begin
        n_vx = 40'(r_pxc) + 40'(r_pys);
        n_vy = 40'(r_pyc) - 40'(r_pxs);
        n_mx = n_vx[39] ? 40'(-n_vx) : 40'(n_vx);
        n_my = n_vy[39] ? 40'(-n_vy) : 40'(n_vy);
        n_mx = n_mx + 40'd8192;
        n_my = n_my + 40'd8192;
        n_d  = 61'(r_xm2_d) + 61'(r_prod);
    end

    gkc_div #(
        .NUM_W (ENV_NUM_W),
        .DEN_W (ENV_DEN_W),
        .Q_W   (ENV_Q)
    ) u_div_env (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_d),
        .i_den  (r_den),
        .o_quot (w_eq)
    );

    always_comb begin
        n_e = (r_sat_d[ENV_Q-1] || (w_eq > EXP_CAP)) ? EXP_CAP : w_eq;
        n_z = 40'(n_e) * 40'(LOG2E_Q16);
        n_w = 46'(r_z[15:0]) * 46'(LN2_Q30);
        w_hw[0] = r_w;
        w_ht[0] = ONE_Q30;
        for (int j = 1; j < HN; j++) begin
            w_hw[j] = r_side[2*j-1].w;
            w_ht[j] = r_ht[j-1];
        end
    end

    gkc_div #(
        .NUM_W (CAR_NUM_W),
        .DEN_W (CAR_DEN_W),
        .Q_W   (CAR_Q)
    ) u_div_car (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_cnum),
        .i_den  (w_lw),
        .o_quot (w_cq)
    );

    assign n_step = r_cneg_d[CAR_Q-1] ? (16'd0 - w_cq[15:0]) : w_cq[15:0];

    gkc_sin u_sin_car (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_turn (r_ang),
        .o_val  (w_car)
    );

    always_comb begin
        n_cm   = r_car_d[CAR_DLY-1][31] ? 31'(-r_car_d[CAR_DLY-1])
                                        : 31'(r_car_d[CAR_DLY-1]);
        n_gc   = 62'(r_g) * 62'(n_cm);
        n_v    = 46'(r_gc) * 46'(r_amplitude);
        n_coef = r_cneg2 ? -$signed(n_v[45:30]) : $signed(n_v[45:30]);
        if (r_oline[TOTAL-2]) begin
            n_coef = '0;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oline[0] <= w_oor;
            for (int i = 1; i < TOTAL; i++) begin
                r_oline[i] <= r_oline[i-1];
            end
            r_dx[0] <= w_dx;
            r_dy[0] <= w_dy;
            for (int i = 1; i < SIN_LAT; i++) begin
                r_dx[i] <= r_dx[i-1];
                r_dy[i] <= r_dy[i-1];
            end

            r_pxc <= 39'(r_dx[SIN_LAT-1]) * 39'(w_ca);
            r_pys <= 39'(r_dy[SIN_LAT-1]) * 39'(w_sa);
            r_pyc <= 39'(r_dy[SIN_LAT-1]) * 39'(w_ca);
            r_pxs <= 39'(r_dx[SIN_LAT-1]) * 39'(w_sa);

            r_xm   <= n_mx[35:14];
            r_ym   <= n_my[35:14];
            r_xneg <= n_vx[39];

            r_xm2   <= 44'(r_xm) * 44'(r_xm);
            r_ym2   <= 44'(r_ym) * 44'(r_ym);
            r_prod  <= 60'(r_ym2[43:16]) * 60'(r_asp2);
            r_xm2_d <= r_xm2;
            r_d     <= n_d;
            r_sat   <= (n_d >= (61'(r_den) << ENV_Q));
            r_sat_d[0] <= r_sat;
            for (int i = 1; i < ENV_Q; i++) begin
                r_sat_d[i] <= r_sat_d[i-1];
            end

            r_z      <= n_z[39:16];
            r_w      <= n_w[45:16];
            r_kbig   <= (r_z[23:16] >= 8'd30);
            r_kshift <= r_z[20:16];
            r_side[0] <= '{w: r_w, kbig: r_kbig, kshift: r_kshift};
            for (int i = 1; i < 2 * HN; i++) begin
                r_side[i] <= r_side[i-1];
            end
            for (int j = 0; j < HN; j++) begin
                r_hp[j] <= 30'((61'(w_hw[j]) * 61'(w_ht[j])) >> 30);
                r_ht[j] <= ONE_Q30 - 31'((61'(r_hp[j]) * 61'(HK_RECIP[j])) >> HK_SHIFT[j]);
            end
            r_g <= r_side[2*HN-1].kbig ? '0 : (r_ht[HN-1] >> r_side[2*HN-1].kshift);

            r_cnum <= 30'({r_xm, 7'd0}) + (r_xneg ? (30'(w_lw) - 30'd1) : 30'd0);
            r_cneg <= r_xneg;
            r_cneg_d[0] <= r_cneg;
            for (int i = 1; i < CAR_Q; i++) begin
                r_cneg_d[i] <= r_cneg_d[i-1];
            end
            r_ang <= r_carrier_phase + n_step + (r_use_sine ? 16'd0 : QUARTER_TURN);
            r_car_d[0] <= w_car;
            for (int i = 1; i < CAR_DLY; i++) begin
                r_car_d[i] <= r_car_d[i-1];
            end

            r_gc    <= n_gc[60:30];
            r_cneg2 <= r_car_d[CAR_DLY-1][31];
            r_coef  <= n_coef;
        end
    end

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else if (!r_ovalid || i_ready) begin
            if (r_svalid) begin
                r_ovalid <= 1'b1;
                r_svalid <= 1'b0;
            end else begin
                r_ovalid <= w_push;
            end
        end else if (w_push) begin
            r_svalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ovalid || i_ready) begin
            if (r_svalid) begin
                r_ocoef <= r_scoef;
                r_ooor  <= r_soor;
            end else begin
                r_ocoef <= r_coef;
                r_ooor  <= r_oline[TOTAL-1];
            end
        end else if (w_push) begin
            r_scoef <= r_coef;
            r_soor  <= r_oline[TOTAL-1];
        end
    end

    assign o_valid        = r_ovalid;
    assign o_coefficient  = r_ocoef;
    assign o_out_of_range = r_ooor;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_svalid |-> r_ovalid)
        else $error("skid entry full while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_svalid) |-> $past(r_ovalid && !i_ready))
        else $error("skid entry filled without a stalled output");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_coefficient == 16'sd0))
        else $error("out of range beat with nonzero coefficient");

    a_coef_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coefficient != -16'sd32768))
        else $error("coefficient beyond amplitude range");
`endif

endmodule

`default_nettype wire
